>>> hw/rtl/tscg_pkg.sv
// ----------------------------------------------------------------------------
// tscg_pkg
// Types and codes shared by the send credit gate modules.
// ----------------------------------------------------------------------------
package tscg_pkg;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_DUMMY = 2'd2,
    KIND_SYN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_NOTHING   = 3'd1,
    ST_THROTTLED = 3'd2,
    ST_LINK_DOWN = 3'd3,
    ST_BLOCKING  = 3'd4,
    ST_DONE      = 3'd5
  } status_t;

  // configuration register indexes
  localparam logic [2:0] REG_LINK_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_WINDOW_MARGIN  = 3'd1;
  localparam logic [2:0] REG_INFLIGHT_LIMIT = 3'd2;
  localparam logic [2:0] REG_WINDOW_SCALE   = 3'd3;
  localparam logic [2:0] REG_MAX_PAYLOAD    = 3'd4;
  localparam logic [2:0] REG_BLOCKING_MODE  = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 21;

  localparam logic        RST_LINK_ACTIVE    = 1'b1;
  localparam logic [15:0] RST_WINDOW_MARGIN  = 16'd2048;
  localparam logic [20:0] RST_INFLIGHT_LIMIT = 21'd8192;
  localparam logic [3:0]  RST_WINDOW_SCALE   = 4'd0;
  localparam logic [15:0] RST_MAX_PAYLOAD    = 16'd1440;
  localparam logic        RST_BLOCKING_MODE  = 1'b0;

  typedef struct packed {
    logic                   write;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // classified event; arg is the ack number for acks, SYN sequence + 1 for SYNs
  typedef struct packed {
    kind_t       kind;
    logic [31:0] arg;
    logic [15:0] window;
    logic [15:0] count;
    logic        zero_count;
    logic        dont_wait;
    logic        from_hardware;
    logic        partial_write;
  } op_t;

  typedef struct packed {
    logic [15:0] grant_length;
    status_t     status;
    logic [63:0] acked_position;
    logic [31:0] send_window;
  } res_t;

endpackage

>>> hw/rtl/tscg_fifo.sv
// ----------------------------------------------------------------------------
// tscg_fifo
// Small show-ahead register queue used between the gate stages.
// ----------------------------------------------------------------------------
module tscg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/tscg_front.sv
// ----------------------------------------------------------------------------
// tscg_front
// Takes input events, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tscg_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    kind,
  input  logic [31:0]   ack_number,
  input  logic [15:0]   peer_window,
  input  logic [15:0]   byte_count,
  input  logic          dont_wait,
  input  logic          from_hardware,
  input  logic          partial_write,
  input  logic [31:0]   syn_sequence,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output tscg_pkg::op_t cmd
);
  import tscg_pkg::*;

  op_t                op_in;
  logic [$bits(op_t)-1:0] cmd_bits;

  always_comb begin
    op_in.kind          = kind_t'(kind);
    // SYN places every position one past its sequence number (32-bit wrap)
    op_in.arg           = (kind_t'(kind) == KIND_SYN) ? syn_sequence + 32'd1 : ack_number;
    op_in.window        = peer_window;
    op_in.count         = byte_count;
    op_in.zero_count    = (byte_count == '0);
    op_in.dont_wait     = dont_wait;
    op_in.from_hardware = from_hardware;
    op_in.partial_write = partial_write;
  end

  tscg_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .full  (full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_bits)
  );

  assign cmd = op_t'(cmd_bits);

endmodule

>>> hw/rtl/tscg_back.sv
// ----------------------------------------------------------------------------
// tscg_back
// Session state and credit decision; one queued event per cycle unless results stall.
// ----------------------------------------------------------------------------
module tscg_back #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  tscg_pkg::cfg_wr_t cfg,
  input  logic              cmd_empty,
  input  tscg_pkg::op_t     cmd,
  output logic              cmd_pop,
  input  logic              res_pop,
  output logic              res_empty,
  output tscg_pkg::res_t    res
);
  import tscg_pkg::*;

  // configuration
  logic        link_active;
  logic [15:0] window_margin;
  logic [20:0] inflight_limit;
  logic [3:0]  window_scale;
  logic [15:0] max_payload;
  logic        blocking_mode;

  // session state; gap is fast sent minus acked, inflight is fast minus stack bytes
  logic [63:0] acked;
  logic [63:0] gap;
  logic [63:0] inflight;
  logic [31:0] last_ack_low;
  logic [31:0] window;
  logic        backpressure;

  logic [63:0] acked_next;
  logic [63:0] gap_next;
  logic [63:0] inflight_next;
  logic [31:0] last_ack_low_next;
  logic [31:0] window_next;
  logic        backpressure_next;

  logic        res_full;
  logic        step;
  logic        carry;
  logic [31:0] acked_hi_next;
  logic [33:0] ack_delta;
  logic [15:0] pay;
  logic [31:0] allowed;
  logic [31:0] unacked_lo;
  logic        gap_big;
  logic        win_fail;
  logic        lim_fail;
  logic        counted;
  logic [15:0] hw_add;
  logic [15:0] stack_add;
  logic [17:0] dummy_delta;
  status_t     status;
  res_t        res_in;
  logic [$bits(res_t)-1:0] res_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_active    <= RST_LINK_ACTIVE;
      window_margin  <= RST_WINDOW_MARGIN;
      inflight_limit <= RST_INFLIGHT_LIMIT;
      window_scale   <= RST_WINDOW_SCALE;
      max_payload    <= RST_MAX_PAYLOAD;
      blocking_mode  <= RST_BLOCKING_MODE;
    end else if (cfg.write) begin
      case (cfg.index)
        REG_LINK_ACTIVE:    link_active    <= cfg.data[0];
        REG_WINDOW_MARGIN:  window_margin  <= cfg.data[15:0];
        REG_INFLIGHT_LIMIT: inflight_limit <= cfg.data[20:0];
        REG_WINDOW_SCALE:   window_scale   <= cfg.data[3:0];
        REG_MAX_PAYLOAD:    max_payload    <= cfg.data[15:0];
        REG_BLOCKING_MODE:  blocking_mode  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign step    = !cmd_empty && !res_full;
  assign cmd_pop = step;

  // ack extension; acked low word can differ from last_ack_low after a SYN
  assign carry         = (cmd.arg < last_ack_low);
  assign acked_hi_next = acked[63:32] + {31'd0, carry};
  assign ack_delta     = {1'b0, carry, cmd.arg} - {2'b00, acked[31:0]};

  // credit checks
  assign pay        = (cmd.count < max_payload) ? cmd.count : max_payload;
  assign allowed    = (window < {16'd0, window_margin}) ? '0
                      : window - {16'd0, window_margin};
  assign unacked_lo = gap[63] ? '0 : gap[31:0];
  assign gap_big    = !gap[63] && (gap[62:32] != '0);
  assign win_fail   = gap_big || (({1'b0, unacked_lo} + {17'd0, pay}) > {1'b0, allowed});
  assign lim_fail   = (inflight > {43'd0, inflight_limit});

  // a partial write with the link down counts as complete
  assign counted     = !(cmd.partial_write && link_active);
  assign hw_add      = cmd.from_hardware ? cmd.count : '0;
  assign stack_add   = counted ? cmd.count : '0;
  assign dummy_delta = {2'b00, hw_add} - {2'b00, stack_add};

  always_comb begin
    status = ST_DONE;
    if (cmd.kind == KIND_SEND) begin
      if (!link_active) begin
        status = ST_LINK_DOWN;
      end else if (cmd.zero_count) begin
        status = ST_NOTHING;
      end else if (backpressure || win_fail || lim_fail) begin
        status = ST_THROTTLED;
      end else if (blocking_mode && !cmd.dont_wait && (pay != cmd.count)) begin
        status = ST_BLOCKING;
      end else begin
        status = ST_GRANTED;
      end
    end
  end

  always_comb begin
    acked_next        = acked;
    gap_next          = gap;
    inflight_next     = inflight;
    last_ack_low_next = last_ack_low;
    window_next       = window;
    backpressure_next = backpressure;
    case (cmd.kind)
      KIND_ACK: begin
        last_ack_low_next = cmd.arg;
        window_next       = {16'd0, cmd.window} << window_scale;
        acked_next        = {acked_hi_next, cmd.arg};
        gap_next          = gap - {{30{ack_delta[33]}}, ack_delta};
      end
      KIND_SEND: begin
        if (status == ST_GRANTED) begin
          gap_next      = gap + {48'd0, pay};
          inflight_next = inflight + {48'd0, pay};
        end
      end
      KIND_DUMMY: begin
        gap_next          = gap + {48'd0, hw_add};
        inflight_next     = inflight + {{46{dummy_delta[17]}}, dummy_delta};
        backpressure_next = !counted;
      end
      KIND_SYN: begin
        acked_next = {32'd0, cmd.arg};
        gap_next   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked        <= '0;
      gap          <= '0;
      inflight     <= '0;
      last_ack_low <= '0;
      window       <= '0;
      backpressure <= 1'b0;
    end else if (step) begin
      acked        <= acked_next;
      gap          <= gap_next;
      inflight     <= inflight_next;
      last_ack_low <= last_ack_low_next;
      window       <= window_next;
      backpressure <= backpressure_next;
    end
  end

  always_comb begin
    res_in.grant_length   = (status == ST_GRANTED) ? pay : '0;
    res_in.status         = status;
    res_in.acked_position = acked_next;
    res_in.send_window    = window_next;
  end

  tscg_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (step),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .empty (res_empty),
    .rdata (res_bits)
  );

  assign res = res_t'(res_bits);

  a_syn_clears_gap: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.kind == KIND_SYN) |=> (gap == '0 && acked[63:32] == '0))
    else $error("SYN did not align fast and acked positions");

  a_grant_counts: assert property (@(posedge clk) disable iff (rst)
    (step && status == ST_GRANTED) |=>
      (inflight == $past(inflight) + {48'd0, $past(pay)}))
    else $error("granted bytes not added to in-flight count");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !cmd_pop)
    else $error("event taken with result queue full");

  a_refused_no_change: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.kind == KIND_SEND && status != ST_GRANTED) |=>
      ($stable(gap) && $stable(inflight)))
    else $error("refused request changed session state");

endmodule

>>> hw/rtl/tcp_send_credit_gate_unit.sv
// ----------------------------------------------------------------------------
// tcp_send_credit_gate_unit
// Fast-path send credit gate for one TCP session.
// ----------------------------------------------------------------------------
// Events enter through a queue-style port: an event transfers on a rising
// edge with push high and full low. Kinds are peer ack, send request,
// dummy written and SYN sent. Every event yields exactly one result, read
// from a queue-style port: the oldest result sits on the result ports while
// empty is low and transfers on an edge with pop high.
// Throughput is one event per cycle while the result queue has room: the
// session registers (acked position, sent gap, in-flight count) update once
// per event in the back end, which sets the rate.
// If the receiver stalls, the result queue fills, the back end holds, and
// the command queue then raises full; nothing is dropped.
// Configuration registers are written through cfg_write/cfg_index/cfg_data.
// The user must write them only while no event is pending; the block itself
// does not enforce this. Reset (rst, synchronous) empties both queues,
// clears the session state and restores register defaults.
// ----------------------------------------------------------------------------
module tcp_send_credit_gate_unit #(
  parameter int CMD_DEPTH    = 2,
  parameter int RESULT_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tscg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tscg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind,
  input  logic [31:0]                     ack_number,
  input  logic [15:0]                     peer_window,
  input  logic [15:0]                     byte_count,
  input  logic                            dont_wait,
  input  logic                            from_hardware,
  input  logic                            partial_write,
  input  logic [31:0]                     syn_sequence,
  output logic                            empty,
  input  logic                            pop,
  output logic [15:0]                     grant_length,
  output logic [2:0]                      status,
  output logic [63:0]                     acked_position,
  output logic [31:0]                     send_window
);
  import tscg_pkg::*;

  cfg_wr_t cfg;
  op_t     cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  res_t    res;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tscg_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .ack_number    (ack_number),
    .peer_window   (peer_window),
    .byte_count    (byte_count),
    .dont_wait     (dont_wait),
    .from_hardware (from_hardware),
    .partial_write (partial_write),
    .syn_sequence  (syn_sequence),
    .cmd_pop       (cmd_pop),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd)
  );

  tscg_back #(
    .DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign grant_length   = res.grant_length;
  assign status         = res.status;
  assign acked_position = res.acked_position;
  assign send_window    = res.send_window;

endmodule

>>> bench/tcp_send_credit_gate_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_send_credit_gate_unit_test
// Self-checking bench for the send credit gate. A directed table of events
// and register writes runs first. Randomized session traffic follows, over
// several register settings. Every result is compared with a session model
// kept inside the bench.
// ----------------------------------------------------------------------------
module tcp_send_credit_gate_unit_test;
  import tscg_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 152;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ack;
    logic [15:0] wnd;
    logic [15:0] cnt;
    logic        dw;
    logic        hw;
    logic        part;
    logic [31:0] syn;
  } sess_ev_t;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   what;
    logic [2:0]  reg_idx;
    logic [20:0] reg_val;
    sess_ev_t    ev;
    logic        fixed;   // grant and status typed in the row
    logic [15:0] grant;
    status_t     st;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [1:0]             kind = '0;
  logic [31:0]            ack_number = '0;
  logic [15:0]            peer_window = '0;
  logic [15:0]            byte_count = '0;
  logic                   dont_wait = 1'b0;
  logic                   from_hardware = 1'b0;
  logic                   partial_write = 1'b0;
  logic [31:0]            syn_sequence = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [15:0]            grant_length;
  logic [2:0]             status;
  logic [63:0]            acked_position;
  logic [31:0]            send_window;

  tcp_send_credit_gate_unit dut (.*);

  // session model: registers and state
  logic        m_link;
  logic [15:0] m_margin;
  logic [20:0] m_limit;
  logic [3:0]  m_scale;
  logic [15:0] m_maxpay;
  logic        m_block;
  logic [63:0] s_fast, s_acked, s_stack_pos, s_tfast, s_tstack;
  logic [31:0] s_last_ack, s_window;
  logic        s_bp;

  res_t     credit_q[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  logic     steady = 1'b0;
  int       holds_asked = 0;
  int       holds_done = 0;
  int       hold_left = 0;
  int       quiet = 0;

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  task automatic session_reset();
    m_link      = RST_LINK_ACTIVE;
    m_margin    = RST_WINDOW_MARGIN;
    m_limit     = RST_INFLIGHT_LIMIT;
    m_scale     = RST_WINDOW_SCALE;
    m_maxpay    = RST_MAX_PAYLOAD;
    m_block     = RST_BLOCKING_MODE;
    s_fast      = '0;
    s_acked     = '0;
    s_stack_pos = '0;
    s_tfast     = '0;
    s_tstack    = '0;
    s_last_ack  = '0;
    s_window    = '0;
    s_bp        = 1'b0;
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [20:0] val);
    case (idx)
      REG_LINK_ACTIVE:    m_link   = val[0];
      REG_WINDOW_MARGIN:  m_margin = val[15:0];
      REG_INFLIGHT_LIMIT: m_limit  = val;
      REG_WINDOW_SCALE:   m_scale  = val[3:0];
      REG_MAX_PAYLOAD:    m_maxpay = val[15:0];
      REG_BLOCKING_MODE:  m_block  = val[0];
      default: ;
    endcase
  endtask

  // advance the session by one event and form its result
  task automatic step_session(input sess_ev_t ev, output res_t r);
    logic [63:0] pay, unacked, allowed, diff, pos;
    r.grant_length = '0;
    r.status = ST_DONE;
    case (ev.kind)
      KIND_ACK: begin
        if (ev.ack < s_last_ack) s_acked = s_acked + 64'h1_0000_0000;
        s_acked = {s_acked[63:32], ev.ack};
        s_last_ack = ev.ack;
        s_window = {16'h0, ev.wnd} << m_scale;
      end
      KIND_SEND: begin
        if (!m_link) r.status = ST_LINK_DOWN;
        else if (ev.cnt == 16'h0) r.status = ST_NOTHING;
        else begin
          pay = (ev.cnt < m_maxpay) ? {48'h0, ev.cnt} : {48'h0, m_maxpay};
          unacked = s_fast - s_acked;
          if (unacked[63]) unacked = 64'h0;
          allowed = ({32'h0, s_window} < {48'h0, m_margin}) ? 64'h0
                    : {32'h0, s_window} - {48'h0, m_margin};
          diff = s_tfast - s_tstack;
          if (s_bp || unacked + pay > allowed || diff > {43'h0, m_limit}) begin
            r.status = ST_THROTTLED;
          end else if (m_block && !ev.dw && pay[15:0] != ev.cnt) begin
            r.status = ST_BLOCKING;
          end else begin
            s_fast = s_fast + pay;
            s_tfast = s_tfast + pay;
            r.grant_length = pay[15:0];
            r.status = ST_GRANTED;
          end
        end
      end
      KIND_DUMMY: begin
        if (ev.hw) begin
          s_fast = s_fast + {48'h0, ev.cnt};
          s_tfast = s_tfast + {48'h0, ev.cnt};
        end
        if (ev.part && m_link) s_bp = 1'b1;
        else begin
          s_bp = 1'b0;
          s_stack_pos = s_stack_pos + {48'h0, ev.cnt};
          s_tstack = s_tstack + {48'h0, ev.cnt};
        end
      end
      KIND_SYN: begin
        pos = {32'h0, ev.syn + 32'd1};
        s_acked = pos;
        s_fast = pos;
        s_stack_pos = pos;
      end
      default: ;
    endcase
    r.acked_position = s_acked;
    r.send_window = s_window;
  endtask

  // offer one event and wait for its transfer
  task automatic push_item(input sess_ev_t ev, input logic fixed,
                           input logic [15:0] g, input status_t st);
    res_t r;
    while (!steady && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    kind          <= ev.kind;
    ack_number    <= ev.ack;
    peer_window   <= ev.wnd;
    byte_count    <= ev.cnt;
    dont_wait     <= ev.dw;
    from_hardware <= ev.hw;
    partial_write <= ev.part;
    syn_sequence  <= ev.syn;
    @(posedge clk);
    while (full) @(posedge clk);
    step_session(ev, r);
    if (fixed) begin
      r.grant_length = g;
      r.status = st;
    end
    credit_q.push_back(r);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (credit_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [20:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic reg_close();
    cfg_write <= 1'b0;
  endtask

  task automatic set_all(input logic link, input logic [15:0] margin,
                         input logic [20:0] limit, input logic [3:0] scale,
                         input logic [15:0] maxpay, input logic block);
    settle();
    reg_write(REG_LINK_ACTIVE, {20'h0, link});
    reg_write(REG_WINDOW_MARGIN, {5'h0, margin});
    reg_write(REG_INFLIGHT_LIMIT, limit);
    reg_write(REG_WINDOW_SCALE, {17'h0, scale});
    reg_write(REG_MAX_PAYLOAD, {5'h0, maxpay});
    reg_write(REG_BLOCKING_MODE, {20'h0, block});
    reg_close();
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [20:0] val);
    dir_row_t row;
    row = '0;
    row.what = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endtask

  task automatic add_ev(input kind_t k, input logic [31:0] ack, input logic [15:0] wnd,
                        input logic [15:0] cnt, input logic dw, input logic hw,
                        input logic part, input logic [31:0] syn, input logic fixed,
                        input logic [15:0] g, input status_t st);
    dir_row_t row;
    row = '0;
    row.what = ROW_EVENT;
    row.ev.kind = k;
    row.ev.ack = ack;
    row.ev.wnd = wnd;
    row.ev.cnt = cnt;
    row.ev.dw = dw;
    row.ev.hw = hw;
    row.ev.part = part;
    row.ev.syn = syn;
    row.fixed = fixed;
    row.grant = g;
    row.st = st;
    dir_rows.push_back(row);
  endtask

  task automatic build_table();
    // fresh session: zero window throttles, empty request, then a full grant
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd100, 0, 0, 0, 32'h0, 1, 16'd0, ST_THROTTLED);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd0, 0, 0, 0, 32'h0, 1, 16'd0, ST_NOTHING);
    add_ev(KIND_ACK, 32'h0, 16'hFFFF, 16'h0, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'hFFFF, 0, 0, 0, 32'h0, 1, 16'd1440, ST_GRANTED);
    // SYN at all-ones wraps to zero; ack goes high then wraps
    add_ev(KIND_SYN, 32'h0, 16'h0, 16'h0, 0, 0, 0, 32'hFFFF_FFFF, 1, 16'd0, ST_DONE);
    add_ev(KIND_ACK, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_ACK, 32'd5, 16'hFFFF, 16'h0, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    // acked ahead of sent: unacked clamps to zero
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd1, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    // window under the margin
    add_ev(KIND_ACK, 32'd6, 16'd100, 16'h0, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd1, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    // blocking mode against a clipped grant, with and without no-wait
    add_reg(REG_BLOCKING_MODE, 21'd1);
    add_ev(KIND_ACK, 32'd6, 16'hFFFF, 16'h0, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd2000, 0, 0, 0, 32'h0, 1, 16'd0, ST_BLOCKING);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd2000, 1, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    // zero payload limit
    add_reg(REG_MAX_PAYLOAD, 21'd0);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd5, 1, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd5, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    add_reg(REG_BLOCKING_MODE, 21'd0);
    add_reg(REG_MAX_PAYLOAD, 21'd1440);
    // hardware bytes on a partial write, then backpressure
    add_ev(KIND_DUMMY, 32'h0, 16'h0, 16'hFFFF, 0, 1, 1, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd10, 0, 0, 0, 32'h0, 1, 16'd0, ST_THROTTLED);
    add_ev(KIND_DUMMY, 32'h0, 16'h0, 16'h0, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd10, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    // stack count overtakes fast count
    add_ev(KIND_DUMMY, 32'h0, 16'h0, 16'hFFFF, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_DUMMY, 32'h0, 16'h0, 16'hFFFF, 0, 0, 0, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd10, 0, 0, 0, 32'h0, 0, 16'd0, ST_DONE);
    // link down: requests refused, partial write counted as complete
    add_reg(REG_LINK_ACTIVE, 21'd0);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd5, 0, 0, 0, 32'h0, 1, 16'd0, ST_LINK_DOWN);
    add_ev(KIND_DUMMY, 32'h0, 16'h0, 16'd100, 0, 0, 1, 32'h0, 1, 16'd0, ST_DONE);
    add_ev(KIND_SEND, 32'h0, 16'h0, 16'd0, 0, 0, 0, 32'h0, 1, 16'd0, ST_LINK_DOWN);
    add_reg(REG_LINK_ACTIVE, 21'd1);
  endtask

  // mostly well-formed session traffic driven off the model state
  task automatic gen_event(input logic opener, output sess_ev_t ev);
    logic [63:0] outstanding, diff, behind;
    logic [31:0] back;
    int          r;
    ev.kind = kind_t'($urandom_range(3));
    ev.ack  = $urandom;
    ev.wnd  = $urandom_range(65535);
    ev.cnt  = $urandom_range(65535);
    ev.dw   = $urandom_range(1);
    ev.hw   = $urandom_range(1);
    ev.part = $urandom_range(1);
    ev.syn  = $urandom;
    r = $urandom_range(99);
    if (opener || r < 2) begin
      ev.kind = KIND_SYN;
      if ($urandom_range(2) == 0) ev.syn = 32'hFFFF_FFFF - $urandom_range(20000);
    end else if (r < 40) begin
      ev.kind = KIND_SEND;
      case ($urandom_range(19))
        0:       ev.cnt = 16'h0;
        1:       ev.cnt = 16'hFFFF;
        default: ev.cnt = $urandom_range(1, 3000);
      endcase
    end else if (r < 62) begin
      ev.kind = KIND_ACK;
      outstanding = s_fast - s_acked;
      back = 32'h0;
      if ($urandom_range(3) == 0 && !outstanding[63] && outstanding < 64'd2000)
        back = $urandom_range(outstanding[31:0]);
      ev.ack = s_fast[31:0] - back;
      // a small step back would read as a wrap
      if (s_last_ack - ev.ack < 32'd65536) ev.ack = s_last_ack;
      if ($urandom_range(4) != 0) ev.wnd = $urandom_range(8192, 65535);
    end else if (r < 88) begin
      ev.kind = KIND_DUMMY;
      diff = s_tfast - s_tstack;
      if (diff[63]) begin
        // stack ahead: hardware bytes on a partial write pull fast count up
        behind = s_tstack - s_tfast;
        ev.hw = 1'b1;
        ev.part = 1'b1;
        ev.cnt = (behind > 64'd65535) ? 16'hFFFF : behind[15:0];
      end else begin
        ev.hw = ($urandom_range(9) == 0);
        ev.part = !s_bp && ($urandom_range(9) == 0);
        if ({48'h0, ev.cnt} > diff) ev.cnt = diff[15:0];
      end
    end
  endtask

  // receiver: random pop, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= 24);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (credit_q.size() == 0) begin
        $error("result with no pending event: status %0d", status);
        errors++;
      end else begin
        want = credit_q.pop_front();
        if (grant_length !== want.grant_length) begin
          $error("grant_length: expected %0d, got %0d", want.grant_length, grant_length);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (acked_position !== want.acked_position) begin
          $error("acked_position: expected %h, got %h", want.acked_position, acked_position);
          errors++;
        end
        if (send_window !== want.send_window) begin
          $error("send_window: expected %h, got %h", want.send_window, send_window);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || cfg_write || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("tcp_send_credit_gate_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sess_ev_t ev;
    logic     cfg_open;
    int       ph;
    int       i;
    cfg_open = 1'b0;
    session_reset();
    build_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].what == ROW_REG) begin
        if (!cfg_open) settle();
        cfg_open = 1'b1;
        reg_write(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        if (cfg_open) reg_close();
        cfg_open = 1'b0;
        push_item(dir_rows[k].ev, dir_rows[k].fixed, dir_rows[k].grant, dir_rows[k].st);
      end
    end
    if (cfg_open) begin
      reg_close();
      @(posedge clk);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_all(RST_LINK_ACTIVE, RST_WINDOW_MARGIN, RST_INFLIGHT_LIMIT,
                   RST_WINDOW_SCALE, RST_MAX_PAYLOAD, RST_BLOCKING_MODE);
        1: set_all(1'b1, 16'h0, 21'h0, 4'd0, 16'd1, 1'b0);
        2: set_all(1'b1, 16'hFFFF, 21'h10_0000, 4'd14, 16'hFFFF, 1'b1);
        default: set_all($urandom_range(9) != 0,
                         $urandom_range(1) ? $urandom_range(4095) : $urandom_range(65535),
                         $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1048576),
                         $urandom_range(14),
                         $urandom_range(1) ? $urandom_range(1, 3000) : $urandom_range(1, 65535),
                         $urandom_range(1));
      endcase
      steady = (ph == 4);
      if (ph == 6) holds_asked++;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        gen_event(i == 0, ev);
        push_item(ev, 1'b0, 16'h0, ST_DONE);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tcp_send_credit_gate_unit verification clean");
    end else begin
      $display("tcp_send_credit_gate_unit verification failed");
    end
    $finish;
  end

endmodule
